>>> sv/two_button_short_long_press_defines.svh
// Assertion macros used by the press detector top level.
`ifndef TWO_BUTTON_SHORT_LONG_PRESS_DEFINES_SVH
`define TWO_BUTTON_SHORT_LONG_PRESS_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge out of reset.
`define TBSLP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tbslp assertion failed");
// Next-cycle implication, checked at every rising edge out of reset.
`define TBSLP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tbslp assertion failed");
`else
`define TBSLP_ASSERT_SAME(label, ante, cons)
`define TBSLP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> sv/tbslp_pkg.sv
// Types, action codes and the per-button step function of the press detector.
package tbslp_pkg;

   localparam int unsigned TimeWidth = 32;
   localparam int unsigned CsrWidth  = 16;

   localparam logic [CsrWidth-1:0] LockoutResetMs   = 16'd50;
   localparam logic [CsrWidth-1:0] LongPressResetMs = 16'd2000;

   // register indexes on the write port
   localparam logic CSR_LOCKOUT    = 1'b0;
   localparam logic CSR_LONG_PRESS = 1'b1;

   // up button action codes
   localparam logic [2:0] UP_NONE    = 3'd0;
   localparam logic [2:0] UP_SCROLL  = 3'd1;
   localparam logic [2:0] UP_VOLUME  = 3'd2;
   localparam logic [2:0] UP_CONFIRM = 3'd3;
   localparam logic [2:0] UP_TOGGLE  = 3'd4;

   // down button action codes
   localparam logic [1:0] DN_NONE   = 2'd0;
   localparam logic [1:0] DN_SCROLL = 2'd1;
   localparam logic [1:0] DN_VOLUME = 2'd2;
   localparam logic [1:0] DN_BACK   = 2'd3;

   typedef struct packed {
      logic [CsrWidth-1:0] lockout_ms;
      logic [CsrWidth-1:0] long_hold_ms;
   } csr_type;

   typedef struct packed {
      logic [TimeWidth-1:0] now_ms;
      logic                 up_level;
      logic                 down_level;
      logic                 audio_playing;
      logic                 menu_open;
   } sample_type;

   typedef struct packed {
      logic                 held;
      logic [TimeWidth-1:0] press_time;
      logic                 long_done;
   } button_type;

   typedef struct packed {
      logic [TimeWidth-1:0] last_event_time;
      button_type           up;
      button_type           down;
   } state_type;

   typedef struct packed {
      logic       stop_audio;
      logic [2:0] up_action;
      logic [1:0] down_action;
   } result_type;

   typedef struct packed {
      button_type btn;
      logic       evt;
      logic       long_hit;
      logic       short_hit;
   } button_step_type;

   // Advance one button by one sample. Elapsed time wraps modulo 2^32.
   function automatic button_step_type button_step(
      input button_type           cur,
      input logic                 level,
      input logic [TimeWidth-1:0] now,
      input logic [CsrWidth-1:0]  long_ms
   );
      button_step_type      res;
      logic [TimeWidth-1:0] start;
      logic                 done;
      logic [TimeWidth-1:0] elapsed;
      logic                 reached;
      start   = cur.held ? cur.press_time : now;
      done    = cur.held ? cur.long_done : 1'b0;
      elapsed = now - start;
      reached = elapsed >= {{(TimeWidth-CsrWidth){1'b0}}, long_ms};
      res     = '0;
      res.btn = cur;
      if (level) begin
         res.btn.held       = 1'b1;
         res.btn.press_time = start;
         res.long_hit       = !done && reached;
         res.btn.long_done  = done || res.long_hit;
         res.evt            = res.long_hit;
      end else if (cur.held) begin
         res.short_hit = !cur.long_done && !reached;
         res.btn       = '0;
         res.evt       = 1'b1;
      end
      return res;
   endfunction

endpackage

>>> sv/tbslp_csr.sv
// Configuration registers: lockout time and long-press time.
module tbslp_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic                           csr_addr,
   input  logic [tbslp_pkg::CsrWidth-1:0] csr_wdata,
   output tbslp_pkg::csr_type             cfg
);

   tbslp_pkg::csr_type cfg_ff;
   tbslp_pkg::csr_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            tbslp_pkg::CSR_LOCKOUT:    cfg_in.lockout_ms   = csr_wdata;
            tbslp_pkg::CSR_LONG_PRESS: cfg_in.long_hold_ms = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lockout_ms   <= tbslp_pkg::LockoutResetMs;
         cfg_ff.long_hold_ms <= tbslp_pkg::LongPressResetMs;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/tbslp_eval.sv
// One-sample evaluation: lockout, audio stop, and short/long press decisions.
module tbslp_eval (
   input  tbslp_pkg::csr_type    cfg,
   input  tbslp_pkg::sample_type sample,
   input  tbslp_pkg::state_type  cur,
   output tbslp_pkg::state_type  nxt,
   output tbslp_pkg::result_type result
);

   logic [tbslp_pkg::TimeWidth-1:0] since_event;
   logic                            locked;
   logic                            stop;
   tbslp_pkg::button_step_type      up_step;
   tbslp_pkg::button_step_type      dn_step;

   assign since_event = sample.now_ms - cur.last_event_time;
   assign locked = since_event <
                   {{(tbslp_pkg::TimeWidth-tbslp_pkg::CsrWidth){1'b0}}, cfg.lockout_ms};
   assign stop = (sample.up_level || sample.down_level) && sample.audio_playing &&
                 !sample.menu_open;

   always_comb begin
      up_step = tbslp_pkg::button_step(cur.up, sample.up_level, sample.now_ms,
                                       cfg.long_hold_ms);
      dn_step = tbslp_pkg::button_step(cur.down, sample.down_level, sample.now_ms,
                                       cfg.long_hold_ms);
      nxt    = cur;
      result = '0;
      priority if (locked) begin
         nxt = cur;
      end else if (stop) begin
         // forget both presses
         nxt                 = '0;
         nxt.last_event_time = sample.now_ms;
         result.stop_audio   = 1'b1;
      end else begin
         nxt.up   = up_step.btn;
         nxt.down = dn_step.btn;
         if (up_step.evt || dn_step.evt) begin
            nxt.last_event_time = sample.now_ms;
         end
         if (up_step.long_hit) begin
            result.up_action = sample.menu_open ? tbslp_pkg::UP_CONFIRM
                                                : tbslp_pkg::UP_TOGGLE;
         end else if (up_step.short_hit) begin
            result.up_action = sample.menu_open ? tbslp_pkg::UP_SCROLL
                                                : tbslp_pkg::UP_VOLUME;
         end
         // long down press outside the menu counts as an event with no action
         if (dn_step.long_hit && sample.menu_open) begin
            result.down_action = tbslp_pkg::DN_BACK;
         end else if (dn_step.short_hit) begin
            result.down_action = sample.menu_open ? tbslp_pkg::DN_SCROLL
                                                  : tbslp_pkg::DN_VOLUME;
         end
      end
   end

endmodule

>>> sv/two_button_short_long_press.sv
// Top level of the two-button short/long press detector.
//
// req_* carries one poll sample per transfer: a wrapping millisecond
// timestamp, the up and down button levels, and the audio/menu status.
// rsp_* returns exactly one result per sample, in order: stop_audio and
// the up and down action codes (all zero when nothing fires or the
// sample falls inside the lockout window after an event).
// csr_* writes lockout_ms (index 0) and long_hold_ms (index 1); write
// only while no sample is in flight.
// Timing: a sample is captured in an input register and evaluated
// combinationally against the press state; the result lands in a result
// register that drives rsp_valid. One sample per cycle is sustained while
// rsp_stall is low; the press-state update loops from the state register
// through a 32-bit subtract and compare per button.
// Reset: synchronous reset empties both stages, clears the press state and
// loads lockout_ms = 50 and long_hold_ms = 2000.
// Back-pressure: while rsp_stall holds a result, the input register keeps
// one more sample; req_stall rises only when both are full and rsp_stall
// is high in that same cycle.
`include "two_button_short_long_press_defines.svh"

module two_button_short_long_press (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tbslp_pkg::TimeWidth-1:0] req_now_ms,
   input  logic                            req_up_level,
   input  logic                            req_down_level,
   input  logic                            req_audio_playing,
   input  logic                            req_menu_open,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_stop_audio,
   output logic [2:0]                      rsp_up_action,
   output logic [1:0]                      rsp_down_action,

   input  logic                            csr_we,
   input  logic                            csr_addr,
   input  logic [tbslp_pkg::CsrWidth-1:0]  csr_wdata
);

   tbslp_pkg::csr_type    cfg;

   logic                  in_valid_ff;
   logic                  in_valid_in;
   tbslp_pkg::sample_type sample_ff;
   tbslp_pkg::sample_type sample_in;

   tbslp_pkg::state_type  state_ff;
   tbslp_pkg::state_type  state_in;
   tbslp_pkg::state_type  state_nxt;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   tbslp_pkg::result_type result_ff;
   tbslp_pkg::result_type result_in;
   tbslp_pkg::result_type result_nxt;

   logic                  advance;
   logic                  req_take;

   tbslp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tbslp_eval u_eval (
      .cfg    (cfg),
      .sample (sample_ff),
      .cur    (state_ff),
      .nxt    (state_nxt),
      .result (result_nxt)
   );

   // Move the captured sample into the result register when that slot is
   // empty or its result transfers this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      sample_in   = sample_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      if (req_take) begin
         sample_in.now_ms        = req_now_ms;
         sample_in.up_level      = req_up_level;
         sample_in.down_level    = req_down_level;
         sample_in.audio_playing = req_audio_playing;
         sample_in.menu_open     = req_menu_open;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         // commit the press state and load the result together
         state_in     = state_nxt;
         rsp_valid_in = 1'b1;
         result_in    = result_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      result_ff <= result_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_stop_audio  = result_ff.stop_audio;
   assign rsp_up_action   = result_ff.up_action;
   assign rsp_down_action = result_ff.down_action;

   // An audio stop result never carries a button action.
   `TBSLP_ASSERT_SAME(a_stop_alone, rsp_valid_ff && result_ff.stop_audio,
      result_ff.up_action == tbslp_pkg::UP_NONE && result_ff.down_action == tbslp_pkg::DN_NONE)
   // An audio stop forgets both presses.
   `TBSLP_ASSERT_NEXT(a_stop_clears, advance && result_nxt.stop_audio,
      !state_ff.up.held && !state_ff.down.held)
   // A waiting sample is never dropped from the input register.
   `TBSLP_ASSERT_NEXT(a_hold_sample, in_valid_ff && !advance, in_valid_ff && $stable(sample_ff))
   // The up action code stays within its defined set.
   `TBSLP_ASSERT_SAME(a_up_code, rsp_valid_ff, result_ff.up_action <= tbslp_pkg::UP_TOGGLE)

endmodule
